### src/mwn_pkg.sv
// Shared constants, types and the sine table function of the waveform oscillator.
package mwn_pkg;

  localparam int PHASE_BITS_DEF  = 24;
  localparam int SINE_DEPTH_DEF  = 1024;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int MODE_W      = 2;
  localparam int INC_W       = 23;
  localparam int NEW_PHASE_W = 24;
  localparam int PHASE_OUT_W = 24;
  localparam int SAMPLE_W    = 16;
  localparam int MAG_W       = 14;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Word index of the phase increment register.
  localparam logic REG_PHASE_INC = 1'b0;

  localparam logic signed [SAMPLE_W-1:0] SQUARE_HIGH = 16'sd8192;
  localparam logic signed [SAMPLE_W-1:0] SQUARE_LOW  = -16'sd8192;

  // Pi and pi/2 in Q2.30.
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  typedef enum logic [MODE_W-1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_TRIANGLE = 2'd1,
    WAVE_SAWTOOTH = 2'd2,
    WAVE_SQUARE   = 2'd3
  } wave_mode_t;

  // Half-amplitude Q1.15 sine of angle x (Q2.30 radians, 0 <= x < 2*pi).
  // The angle folds to the first quadrant and an eleventh-order Taylor series
  // in Q2.30 gives the value. Only evaluated while the table is elaborated.
  function automatic logic signed [SAMPLE_W-1:0] sine_from_x(logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] v;
    longint sum;
    logic neg;
    logic signed [SAMPLE_W-1:0] mag;
    begin
      x   = x_in;
      neg = 1'b0;
      if (x >= PI_Q30) begin
        x   = x - PI_Q30;
        neg = 1'b1;
      end
      if (x > PI_HALF_Q30) begin
        x = PI_Q30 - x;
      end
      x2   = (x * x) >> 30;
      sum  = longint'(x);
      term = ((x * x2) >> 30) / 64'd6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - longint'(term);
      if (sum < 0) begin
        sum = 0;
      end
      v = (64'(sum) + 64'd32768) >> 16;
      if (v > 64'd16384) begin
        v = 64'd16384;
      end
      mag = SAMPLE_W'(v);
      return neg ? -mag : mag;
    end
  endfunction

endpackage

### src/multi_waveform_nco_unit.sv
// Top level of the multi-waveform phase-accumulator oscillator.
// Each transfer on the in_ channel requests one sample and, with in_load_phase
// set, first replaces the phase with in_new_phase. The phase then advances by the
// phase increment register (APB word 0) modulo one cycle, and one result with the
// half-amplitude Q1.15 sample and the new phase follows on the out_ channel. The
// block takes one request per clock cycle while the queue is not full; that rate is
// set by the accumulator add in the front end and the registered sine table read in
// the back end. A result is offered on the out_ channel once its request has passed
// through the queue and the output register, and a two-entry queue between the stages
// absorbs output stalls.
module multi_waveform_nco_unit
  import mwn_pkg::*;
#(
  parameter int PHASE_BITS       = PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
  parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [CFG_ADDR_W-1:0]      paddr,
  input  logic [CFG_DATA_W-1:0]      pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [MODE_W-1:0]          in_mode,
  input  logic                       in_load_phase,
  input  logic [NEW_PHASE_W-1:0]     in_new_phase,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic [PHASE_OUT_W-1:0]     out_phase_now
);

  localparam int QW = MODE_W + PHASE_BITS;

  logic [INC_W-1:0]      phase_inc_r;
  logic                  cfg_write;
  logic                  q_full;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_not_empty;
  logic [MODE_W-1:0]     push_mode;
  logic [PHASE_BITS-1:0] push_phase;
  logic [QW-1:0]         head;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r <= '0;
    end else if (cfg_write && paddr[2] == REG_PHASE_INC) begin
      phase_inc_r <= pwdata[INC_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_PHASE_INC) ? CFG_DATA_W'(phase_inc_r) : '0;

  mwn_front #(
    .PHASE_BITS(PHASE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_load_phase(in_load_phase),
    .in_new_phase (in_new_phase),
    .phase_inc    (phase_inc_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_mode       (push_mode),
    .q_phase      (push_phase)
  );

  mwn_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data({push_mode, push_phase}),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head_data(head)
  );

  mwn_back #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_not_empty),
    .q_mode       (head[QW-1:PHASE_BITS]),
    .q_phase      (head[PHASE_BITS-1:0]),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sample   (out_sample),
    .out_phase_now(out_phase_now)
  );

endmodule

### src/mwn_front.sv
// Front end: accepts requests, keeps the phase accumulator and queues phase and mode.
module mwn_front
  import mwn_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [MODE_W-1:0]      in_mode,
  input  logic                   in_load_phase,
  input  logic [NEW_PHASE_W-1:0] in_new_phase,
  input  logic [INC_W-1:0]       phase_inc,
  input  logic                   q_full,
  output logic                   q_push,
  output logic [MODE_W-1:0]      q_mode,
  output logic [PHASE_BITS-1:0]  q_phase
);

  logic [PHASE_BITS-1:0] phase_acc_r;
  logic [PHASE_BITS-1:0] phase_acc_nxt;
  logic [PHASE_BITS-1:0] inc_m;
  logic [PHASE_BITS-1:0] base;

  // Increment and loaded phase keep only the accumulator's width.
  assign inc_m = PHASE_BITS'(phase_inc);
  assign base  = in_load_phase ? PHASE_BITS'(in_new_phase) : phase_acc_r;

  // Modulo-one-cycle wrap falls out of the fixed accumulator width.
  assign phase_acc_nxt = base + inc_m;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign q_mode   = in_mode;
  assign q_phase  = phase_acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
    end else if (q_push) begin
      phase_acc_r <= phase_acc_nxt;
    end
  end

  a_load_phase : assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && in_load_phase) |=>
      phase_acc_r == $past(PHASE_BITS'(in_new_phase) + inc_m))
    else $error("loaded phase not advanced by the increment");

  a_advance : assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !in_load_phase) |=> phase_acc_r == $past(phase_acc_r + inc_m))
    else $error("phase did not advance by the increment");

  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !q_push |=> $stable(phase_acc_r))
    else $error("phase changed without a transfer");

endmodule

### src/mwn_queue.sv
// Short FIFO between the front end and the waveform back end.
module mwn_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_data = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into a full queue");

  a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from an empty queue");

  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

### src/mwn_back.sv
// Back end: sine table lookup, triangle, sawtooth and square shaping, output register.
module mwn_back
  import mwn_pkg::*;
#(
  parameter int PHASE_BITS       = PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  logic [MODE_W-1:0]          q_mode,
  input  logic [PHASE_BITS-1:0]      q_phase,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic [PHASE_OUT_W-1:0]     out_phase_now
);

  localparam int IDXW = $clog2(SINE_TABLE_DEPTH);
  localparam int PW   = PHASE_BITS + IDXW;
  localparam logic [PHASE_BITS-1:0] PHASE_HALF = {1'b1, {(PHASE_BITS - 1){1'b0}}};

  logic signed [SAMPLE_W-1:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [63:0] XG = (64'(g) * 64'd2 * PI_Q30) / SINE_TABLE_DEPTH;
    assign sine_rom[g] = sine_from_x(XG);
  end

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic signed [SAMPLE_W-1:0] sine_rd_r;
  logic                       use_sine_r;
  logic [PHASE_OUT_W-1:0]     out_phase_r;

  logic [PW-1:0]              idx_prod;
  logic [IDXW-1:0]            sine_idx;
  logic                       upper_half;
  logic [PHASE_BITS-1:0]      half_off;
  logic [PHASE_BITS-1:0]      tri_base;
  logic [PHASE_BITS+MAG_W-1:0] saw_scaled;
  logic [PHASE_BITS+MAG_W-1:0] tri_scaled;
  logic [MAG_W-1:0]           saw_mag;
  logic [MAG_W-1:0]           tri_mag;
  logic signed [SAMPLE_W-1:0] shape;
  wave_mode_t                 mode;

  assign mode = wave_mode_t'(q_mode);

  // Table index is floor(phase * depth / one cycle).
  assign idx_prod = PW'(q_phase) * PW'(SINE_TABLE_DEPTH);
  assign sine_idx = idx_prod[PW-1:PHASE_BITS];

  // Distance from half a cycle drives both sawtooth and triangle.
  assign upper_half = (q_phase >= PHASE_HALF);
  assign half_off   = upper_half ? (q_phase - PHASE_HALF) : (PHASE_HALF - q_phase);
  assign tri_base   = PHASE_HALF - half_off;

  // Scale by 2^14 / one cycle, truncating.
  assign saw_scaled = {half_off, {MAG_W{1'b0}}};
  assign tri_scaled = {tri_base, {MAG_W{1'b0}}};
  assign saw_mag    = saw_scaled[PHASE_BITS+MAG_W-1:PHASE_BITS];
  assign tri_mag    = tri_scaled[PHASE_BITS+MAG_W-1:PHASE_BITS];

  always_comb begin
    unique case (mode)
      WAVE_SINE: begin
        // The sine value comes from its own table output register.
        shape = '0;
      end
      WAVE_TRIANGLE: begin
        shape = -$signed({2'b00, tri_mag});
      end
      WAVE_SAWTOOTH: begin
        shape = upper_half ? $signed({2'b00, saw_mag}) : -$signed({2'b00, saw_mag});
      end
      WAVE_SQUARE: begin
        // Exactly half a cycle still counts as the high half.
        shape = (q_phase > PHASE_HALF) ? SQUARE_LOW : SQUARE_HIGH;
      end
    endcase
  end

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sine_rd_r    <= sine_rom[sine_idx];
      use_sine_r   <= (mode == WAVE_SINE);
      out_sample_r <= shape;
      out_phase_r  <= PHASE_OUT_W'(q_phase);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sample    = use_sine_r ? sine_rd_r : out_sample_r;
  assign out_phase_now = out_phase_r;

  a_pop_fills : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid_r)
    else $error("popped item did not reach the output register");

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !q_pop)
    else $error("waiting result overwritten");

  a_square_level : assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && mode == WAVE_SQUARE) |=>
      (out_sample_r == SQUARE_HIGH || out_sample_r == SQUARE_LOW))
    else $error("square sample off its two levels");

endmodule

### tb/tb.sv
// Self-checking testbench for the multi-waveform phase-accumulator oscillator.
`timescale 1ns / 100ps

module tb
  import mwn_pkg::*;
();

  localparam int CYCLE_LIMIT = 300000;
  localparam logic [63:0] HALF_CYCLE = 64'h800000;

  typedef struct packed {
    wave_mode_t                 mode;
    logic                       load;
    logic [NEW_PHASE_W-1:0]     new_phase;
  } nco_req_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]        sample;
    logic [PHASE_OUT_W-1:0]     phase;
  } nco_out_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]      paddr = '0;
  logic [CFG_DATA_W-1:0]      pwdata = '0;
  logic [CFG_DATA_W-1:0]      prdata;
  logic                       pready;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [MODE_W-1:0]          in_mode = '0;
  logic                       in_load_phase = 1'b0;
  logic [NEW_PHASE_W-1:0]     in_new_phase = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic [PHASE_OUT_W-1:0]     out_phase_now;

  // Predictor state and configuration.
  logic [23:0]                phase_acc = '0;
  logic [INC_W-1:0]           phase_step = '0;
  logic signed [SAMPLE_W-1:0] sine_lut [0:1023];

  nco_req_t req_q[$];
  nco_out_t sample_due_q[$];
  int       pushed_cnt = 0;
  int       accepted_cnt = 0;
  int       rcv_cnt = 0;
  int       error_cnt = 0;
  int       cycle_cnt = 0;

  multi_waveform_nco_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_load_phase(in_load_phase),
    .in_new_phase (in_new_phase),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sample   (out_sample),
    .out_phase_now(out_phase_now)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Advances the oscillator by one request and returns the sample it yields.
  function automatic nco_out_t nco_advance(input wave_mode_t mode, input logic load,
                                           input logic [23:0] new_phase);
    logic [63:0] m;
    int          s;
    nco_out_t    r;
    if (load) phase_acc = new_phase;
    phase_acc = phase_acc + 24'(phase_step);
    case (mode)
      WAVE_SINE: s = int'(sine_lut[phase_acc[23:14]]);
      WAVE_TRIANGLE: begin
        m = (64'(phase_acc) >= HALF_CYCLE) ? 64'(phase_acc) - HALF_CYCLE
                                           : HALF_CYCLE - 64'(phase_acc);
        m = HALF_CYCLE - m;
        s = -int'((m << 14) >> 24);
      end
      WAVE_SAWTOOTH: begin
        if (64'(phase_acc) >= HALF_CYCLE) s = int'(((64'(phase_acc) - HALF_CYCLE) << 14) >> 24);
        else s = -int'(((HALF_CYCLE - 64'(phase_acc)) << 14) >> 24);
      end
      default: s = (64'(phase_acc) > HALF_CYCLE) ? int'(SQUARE_LOW) : int'(SQUARE_HIGH);
    endcase
    r.sample = SAMPLE_W'(s);
    r.phase  = phase_acc;
    return r;
  endfunction

  task automatic queue_item(input wave_mode_t mode, input logic load,
                            input logic [23:0] new_phase);
    nco_req_t r;
    r.mode      = mode;
    r.load      = load;
    r.new_phase = new_phase;
    req_q.push_back(r);
    pushed_cnt++;
  endtask

  // Mostly random phases, with some picked so the advance lands on half a
  // cycle or wraps to exactly zero under the current step.
  task automatic queue_random(input int n);
    nco_req_t r;
    int       pick;
    for (int i = 0; i < n; i++) begin
      r.mode = wave_mode_t'($urandom_range(0, 3));
      r.load = ($urandom_range(0, 3) == 0);
      pick   = $urandom_range(0, 9);
      case (pick)
        0:       r.new_phase = 24'h800000 - 24'(phase_step);
        1:       r.new_phase = 24'h000000 - 24'(phase_step);
        2:       r.new_phase = 24'hFFFFFF;
        3:       r.new_phase = 24'h000000;
        default: r.new_phase = 24'($urandom());
      endcase
      req_q.push_back(r);
      pushed_cnt++;
    end
  endtask

  task automatic drain();
    while (accepted_cnt != pushed_cnt || sample_due_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_phase_step(input logic [INC_W-1:0] step);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({REG_PHASE_INC, 2'b00});
    pwdata  <= CFG_DATA_W'(step);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    phase_step = step;
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin : sender
    nco_req_t item;
    static int burst_left = 8;
    static int gap_left = 0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        sample_due_q.push_back(nco_advance(wave_mode_t'(in_mode), in_load_phase, in_new_phase));
        accepted_cnt++;
      end
      if (in_valid && !in_ready) begin
        // Hold the offered item until the transfer happens.
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (req_q.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        item = req_q.pop_front();
        in_valid      <= 1'b1;
        in_mode       <= item.mode;
        in_load_phase <= item.load;
        in_new_phase  <= item.new_phase;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // Receiver: checks each result and stalls on a pattern that changes style
  // now and then, with two long hold-offs that back the block up.
  always @(posedge clk) begin : receiver
    nco_out_t due;
    logic     rdy;
    static int hold_left = 0;
    static int style = 0;
    static int pat_cyc = 0;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (sample_due_q.size() == 0) begin
          error_cnt++;
          $display("%0t: result with nothing pending: sample %0d phase %h", $time,
                   out_sample, out_phase_now);
        end else begin
          due = sample_due_q.pop_front();
          if (out_sample !== due.sample) begin
            error_cnt++;
            $display("%0t: sample mismatch: expected %0d actual %0d", $time,
                     $signed(due.sample), out_sample);
          end
          if (out_phase_now !== due.phase) begin
            error_cnt++;
            $display("%0t: phase mismatch: expected %h actual %h", $time,
                     due.phase, out_phase_now);
          end
        end
        rcv_cnt++;
        if (rcv_cnt == 300 || rcv_cnt == 1100) hold_left = 400;
      end
      pat_cyc++;
      if (pat_cyc % 97 == 0) style = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (style)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom_range(0, 1));
          2:       rdy = (pat_cyc % 4) != 0;
          default: rdy = ($urandom_range(0, 4) == 0);
        endcase
      end
      out_ready <= rdy;
    end
  end

  initial begin : stimulus
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] v;
    longint      sum;
    logic        neg;
    logic [INC_W-1:0] steps [8];

    // Sine table: fold to the first quadrant, then a Taylor series in Q2.30.
    for (int idx = 0; idx < 1024; idx++) begin
      x   = (64'(idx) * 64'd2 * PI_Q30) / 64'd1024;
      neg = 1'b0;
      if (x >= PI_Q30) begin
        x   = x - PI_Q30;
        neg = 1'b1;
      end
      if (x > PI_Q30 / 64'd2) x = PI_Q30 - x;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 5; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (64'(sum) + 64'd32768) >> 16;
      if (v > 64'd16384) v = 64'd16384;
      sine_lut[idx] = neg ? -SAMPLE_W'(v) : SAMPLE_W'(v);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Zero step: the loaded phase comes straight out, including half a cycle.
    queue_item(WAVE_SINE, 1'b1, 24'h000000);
    queue_item(WAVE_TRIANGLE, 1'b1, 24'h000000);
    queue_item(WAVE_SAWTOOTH, 1'b1, 24'h000000);
    queue_item(WAVE_SQUARE, 1'b1, 24'h000000);
    queue_item(WAVE_SINE, 1'b1, 24'h800000);
    queue_item(WAVE_TRIANGLE, 1'b1, 24'h800000);
    queue_item(WAVE_SAWTOOTH, 1'b1, 24'h800000);
    queue_item(WAVE_SQUARE, 1'b1, 24'h800000);
    queue_item(WAVE_SINE, 1'b1, 24'hFFFFFF);
    queue_item(WAVE_TRIANGLE, 1'b1, 24'hFFFFFF);
    queue_item(WAVE_SAWTOOTH, 1'b1, 24'hFFFFFF);
    queue_item(WAVE_SQUARE, 1'b1, 24'hFFFFFF);
    queue_item(WAVE_SQUARE, 1'b1, 24'h7FFFFF);
    queue_item(WAVE_SQUARE, 1'b1, 24'h800001);
    drain();

    // Largest step: a sum of exactly one cycle wraps to zero.
    set_phase_step(23'h7FFFFF);
    queue_item(WAVE_SINE, 1'b1, 24'h800001);
    queue_item(WAVE_SQUARE, 1'b0, 24'h000000);
    queue_item(WAVE_TRIANGLE, 1'b0, 24'hABCDEF);
    queue_item(WAVE_SAWTOOTH, 1'b0, 24'h123456);
    queue_item(WAVE_SAWTOOTH, 1'b1, 24'h000001);
    queue_item(WAVE_TRIANGLE, 1'b1, 24'h000001);
    queue_item(WAVE_SINE, 1'b1, 24'hFFFFFF);
    drain();

    steps[0] = 23'd1;
    steps[1] = 23'd37;
    steps[2] = 23'd4096;
    steps[3] = 23'h7FFFFF;
    steps[4] = 23'($urandom_range(0, 23'h7FFFFF));
    steps[5] = 23'd0;
    steps[6] = 23'h2AAAAA;
    steps[7] = 23'($urandom_range(0, 23'h7FFFFF));
    foreach (steps[i]) begin
      repeat (4) @(negedge clk);
      set_phase_step(steps[i]);
      @(negedge clk);
      queue_random(102);
      // The stimulus pauses here until every pending result is back.
      drain();
      queue_random(103);
      drain();
    end

    repeat (8) @(negedge clk);
    if (sample_due_q.size() != 0) begin
      error_cnt++;
      $display("%0t: %0d results never arrived", $time, sample_due_q.size());
    end
    if (error_cnt == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
